### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes of the sleep timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    // A tick wakes at most this many sleepers.
    localparam int MAX_WAKE = 16;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;

    localparam logic [2:0] K_ADDED     = 3'd0;
    localparam logic [2:0] K_FULL      = 3'd1;
    localparam logic [2:0] K_WOKEN     = 3'd2;
    localparam logic [2:0] K_CANCELLED = 3'd3;
    localparam logic [2:0] K_NOT_FOUND = 3'd4;
    localparam logic [2:0] K_NOTHING   = 3'd5;

    localparam logic [63:0] TIME_NEVER = '1;

    typedef struct packed {
        logic [63:0] wake_time;
        logic [7:0]  sleeper;
    } entry_t;

endpackage

`default_nettype wire

### design/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data holds while the read enable is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/sleep_timer_queue.sv
// ----------------------------------------------------------------------------
// sleep_timer_queue
// Queue of sleeping tasks kept in wake-time order behind its own tick count.
// ----------------------------------------------------------------------------
// Usage. One input channel (in_valid / in_ready) carries a command word:
// operation 0 adds task_id to wake at now + wake_delay (saturating, placed
// after equal wake times), 1 advances time by one tick and wakes every due
// task (at most sixteen per tick, earliest first), 2 cancels the earliest
// queued entry with task_id. The output channel (out_valid / out_ready)
// returns one word per result: kind, woken_task, next_wake_time (earliest
// wake time left after the whole command, all ones when empty) and last,
// which marks the final word of a command. Add, cancel and every other
// command give one word; a tick gives one word per woken task, or one
// "nothing due" word.
// Timing. The queue lives in one memory with one read and one write port
// and a registered read, so every command walks the entries one a cycle
// while the output is not stalled. An add walks down from the tail to
// the insertion point, a cancel searches from the head, and a tick counts
// the due entries, re-reads them to send and then shifts the rest down.
// One command is in work at a time; in_ready returns once it has finished.
// Reset empties the queue and sets the time to zero; no memory sweep is
// needed. A stalled receiver holds the output word in its register and
// the sequencer waits in place until the word is taken; a new command may
// be taken while the last word of the previous one is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module sleep_timer_queue #(
    parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  task_id,
    input  logic [31:0] wake_delay,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  woken_task,
    output logic [63:0] next_wake_time,
    output logic        last
);

    import stq_pkg::*;

    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int WAKE_LIM = (QUEUE_DEPTH < MAX_WAKE) ? QUEUE_DEPTH : MAX_WAKE;
    localparam logic [CNT_W-1:0] WAKE_LIM_C = CNT_W'(WAKE_LIM);
    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(QUEUE_DEPTH);

    // The sequencer steps through the memory one entry a cycle unless the output
    // stalls. Scan states see in rd the cur_reg entry, read in the cycle before.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,     // walk down from the tail, moving later entries up
        S_ADD_PUT,      // new entry goes to the head
        S_TICK_SCAN,    // count the due entries from the head
        S_TICK_PEEK,    // fetch the wake time after the last woken entry
        S_TICK_EMIT,    // re-read and send the woken entries
        S_SHIFT,        // close the gap left by woken or cancelled entries
        S_CAN_SCAN,     // search the id from the head
        S_RESULT        // send the single result word
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [63:0]        now_reg;
    logic [63:0]        head_reg;      // wake time of entry 0, all ones if empty
    logic [IDX_W-1:0]   cur_reg;
    logic [CNT_W-1:0]   k_reg;         // entries removed (woken from the front, or one cancelled)
    logic [63:0]        t_reg;
    logic [7:0]         id_reg;
    logic [1:0]         op_reg;
    logic [63:0]        next_reg;
    logic [2:0]         res_kind_reg;

    logic               out_valid_reg;
    logic [2:0]         kind_reg;
    logic [7:0]         woken_reg;
    logic [63:0]        next_out_reg;
    logic               last_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             rd;

    logic               accept;
    logic               out_free;
    logic               word_load;
    logic [CNT_W-1:0]   cur_ext;
    logic [CNT_W-1:0]   cur_inc;
    logic [IDX_W-1:0]   shift_dst;
    logic [64:0]        sum;
    logic [63:0]        t_new;
    logic [63:0]        now_inc;
    logic               due;
    entry_t             new_entry;

    stq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign out_free       = !out_valid_reg || out_ready;

    // A new word enters the output register in this cycle.
    assign word_load      = out_free &&
                            (state_reg == S_TICK_EMIT || state_reg == S_RESULT);

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign woken_task     = woken_reg;
    assign next_wake_time = next_out_reg;
    assign last           = last_reg;

    assign cur_ext   = CNT_W'(cur_reg);
    assign cur_inc   = cur_ext + CNT_W'(1);
    assign shift_dst = IDX_W'(cur_ext - k_reg);

    // Wake time of an add saturates at the end of time.
    assign sum       = {1'b0, now_reg} + {33'b0, wake_delay};
    assign t_new     = sum[64] ? TIME_NEVER : sum[63:0];
    assign now_inc   = (now_reg == TIME_NEVER) ? now_reg : now_reg + 64'd1;
    assign due       = (rd.wake_time <= now_reg);
    assign new_entry = '{wake_time: t_reg, sleeper: id_reg};

    // Memory port control. A write and a read never hit the same entry in
    // one cycle: the walks always read ahead of the entry they write.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = rd;
        ram_re    = 1'b0;
        ram_raddr = cur_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && count_reg != '0)
                begin
                    if (operation == OP_ADD && count_reg != DEPTH_C)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = IDX_W'(count_reg - CNT_W'(1));
                    end
                    else if (operation == OP_TICK || operation == OP_CANCEL)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                    end
                end
            end
            S_ADD_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_inc[IDX_W-1:0];
                if (rd.wake_time > t_reg)
                begin
                    ram_wdata = rd;
                    if (cur_reg != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    ram_wdata = new_entry;
                end
            end
            S_ADD_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = new_entry;
            end
            S_TICK_SCAN:
            begin
                if (due && cur_inc != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_inc[IDX_W-1:0];
                end
                else if (due || cur_reg != '0)
                begin
                    // Stopping with tasks to wake: start the re-read at the head.
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
            end
            S_TICK_PEEK:
            begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            S_TICK_EMIT:
            begin
                if (out_free)
                begin
                    if (cur_inc != k_reg)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_inc[IDX_W-1:0];
                    end
                    else if (k_reg != count_reg)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = k_reg[IDX_W-1:0];
                    end
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = shift_dst;
                ram_wdata = rd;
                if (cur_inc != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_inc[IDX_W-1:0];
                end
            end
            S_CAN_SCAN:
            begin
                if (cur_inc != count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_inc[IDX_W-1:0];
                end
            end
            S_RESULT:
            begin
                ram_re = 1'b0;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            head_reg      <= TIME_NEVER;
            cur_reg       <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
            id_reg        <= '0;
            op_reg        <= OP_ADD;
            next_reg      <= TIME_NEVER;
            res_kind_reg  <= K_NOTHING;
            out_valid_reg <= 1'b0;
            kind_reg      <= K_NOTHING;
            woken_reg     <= '0;
            next_out_reg  <= TIME_NEVER;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !word_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= operation;
                        t_reg  <= t_new;
                        id_reg <= (operation == OP_ADD || operation == OP_CANCEL)
                                  ? task_id : 8'd0;
                        unique case (operation)
                            OP_ADD:
                            begin
                                if (count_reg == DEPTH_C)
                                begin
                                    res_kind_reg <= K_FULL;
                                    state_reg    <= S_RESULT;
                                end
                                else if (count_reg == '0)
                                begin
                                    state_reg <= S_ADD_PUT;
                                end
                                else
                                begin
                                    cur_reg   <= IDX_W'(count_reg - CNT_W'(1));
                                    state_reg <= S_ADD_SCAN;
                                end
                            end
                            OP_TICK:
                            begin
                                now_reg <= now_inc;
                                if (count_reg == '0)
                                begin
                                    res_kind_reg <= K_NOTHING;
                                    state_reg    <= S_RESULT;
                                end
                                else
                                begin
                                    cur_reg   <= '0;
                                    state_reg <= S_TICK_SCAN;
                                end
                            end
                            OP_CANCEL:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_kind_reg <= K_NOT_FOUND;
                                    state_reg    <= S_RESULT;
                                end
                                else
                                begin
                                    cur_reg   <= '0;
                                    state_reg <= S_CAN_SCAN;
                                end
                            end
                            default:
                            begin
                                res_kind_reg <= K_NOTHING;
                                state_reg    <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_ADD_SCAN:
                begin
                    if (rd.wake_time > t_reg)
                    begin
                        if (cur_reg == '0)
                        begin
                            state_reg <= S_ADD_PUT;
                        end
                        else
                        begin
                            cur_reg <= cur_reg - IDX_W'(1);
                        end
                    end
                    else
                    begin
                        count_reg    <= count_reg + CNT_W'(1);
                        res_kind_reg <= K_ADDED;
                        state_reg    <= S_RESULT;
                    end
                end

                S_ADD_PUT:
                begin
                    head_reg     <= t_reg;
                    count_reg    <= count_reg + CNT_W'(1);
                    res_kind_reg <= K_ADDED;
                    state_reg    <= S_RESULT;
                end

                S_TICK_SCAN:
                begin
                    if (due)
                    begin
                        if (cur_inc == count_reg)
                        begin
                            k_reg     <= count_reg;
                            next_reg  <= TIME_NEVER;
                            cur_reg   <= '0;
                            state_reg <= S_TICK_EMIT;
                        end
                        else if (cur_inc == WAKE_LIM_C)
                        begin
                            k_reg     <= cur_inc;
                            cur_reg   <= cur_inc[IDX_W-1:0];
                            state_reg <= S_TICK_PEEK;
                        end
                        else
                        begin
                            cur_reg <= cur_inc[IDX_W-1:0];
                        end
                    end
                    else if (cur_reg == '0)
                    begin
                        res_kind_reg <= K_NOTHING;
                        state_reg    <= S_RESULT;
                    end
                    else
                    begin
                        k_reg     <= cur_ext;
                        next_reg  <= rd.wake_time;
                        cur_reg   <= '0;
                        state_reg <= S_TICK_EMIT;
                    end
                end

                S_TICK_PEEK:
                begin
                    next_reg  <= rd.wake_time;
                    cur_reg   <= '0;
                    state_reg <= S_TICK_EMIT;
                end

                S_TICK_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= K_WOKEN;
                        woken_reg     <= rd.sleeper;
                        next_out_reg  <= next_reg;
                        last_reg      <= (cur_inc == k_reg);
                        if (cur_inc == k_reg)
                        begin
                            if (k_reg == count_reg)
                            begin
                                count_reg <= '0;
                                head_reg  <= TIME_NEVER;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                cur_reg   <= k_reg[IDX_W-1:0];
                                state_reg <= S_SHIFT;
                            end
                        end
                        else
                        begin
                            cur_reg <= cur_inc[IDX_W-1:0];
                        end
                    end
                end

                S_SHIFT:
                begin
                    if (shift_dst == '0)
                    begin
                        head_reg <= rd.wake_time;
                    end
                    if (cur_inc == count_reg)
                    begin
                        count_reg <= count_reg - k_reg;
                        state_reg <= (op_reg == OP_TICK) ? S_IDLE : S_RESULT;
                    end
                    else
                    begin
                        cur_reg <= cur_inc[IDX_W-1:0];
                    end
                end

                S_CAN_SCAN:
                begin
                    if (rd.sleeper == id_reg)
                    begin
                        res_kind_reg <= K_CANCELLED;
                        if (cur_inc == count_reg)
                        begin
                            // Last entry removed: nothing to close up.
                            count_reg <= count_reg - CNT_W'(1);
                            if (count_reg == CNT_W'(1))
                            begin
                                head_reg <= TIME_NEVER;
                            end
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            k_reg     <= CNT_W'(1);
                            cur_reg   <= cur_inc[IDX_W-1:0];
                            state_reg <= S_SHIFT;
                        end
                    end
                    else if (cur_inc == count_reg)
                    begin
                        res_kind_reg <= K_NOT_FOUND;
                        state_reg    <= S_RESULT;
                    end
                    else
                    begin
                        cur_reg <= cur_inc[IDX_W-1:0];
                    end
                end

                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= res_kind_reg;
                        woken_reg     <= id_reg;
                        next_out_reg  <= head_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/stq_checker.sv
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the sleep timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  kind,
    input wire logic [7:0]  woken_task,
    input wire logic [63:0] next_wake_time,
    input wire logic        last
);

    import stq_pkg::*;

    // A stalled output word holds still.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(woken_task) && $stable(next_wake_time) && $stable(last))

    // Only a tick can produce several words; every other word closes its command.
    `ASSERT_IMPLIES(a_single_word, clk, rst_n, out_valid && kind != K_WOKEN, last)

    // A "nothing due" word carries no task.
    `ASSERT_IMPLIES(a_nothing_no_task, clk, rst_n, out_valid && kind == K_NOTHING, woken_task == 8'd0)

    // One command is in work at a time.
    `ASSERT_NEXT(a_one_command, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind sleep_timer_queue stq_checker u_stq_checker (.*);

`default_nettype wire
